// File: rtl/core/hilbert_curve_move_generator_core_macros.svh
// Assertion macros for the port-level checker of the move generator.
`ifndef HILBERT_CURVE_MOVE_GENERATOR_CORE_MACROS_SVH
`define HILBERT_CURVE_MOVE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HCMG_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HCMG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hcmg_pkg.sv
// Types, constants and curve tables of the Hilbert move generator.
package hcmg_pkg;

    localparam int MAX_DEPTH  = 8;
    localparam int LVL_W      = $clog2(MAX_DEPTH);
    localparam int DEPTH_W    = 4;
    localparam int MOVES_W    = 2 * MAX_DEPTH;
    localparam int CURSOR_W   = 16;
    localparam int STEP_W     = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] PHASE_FULL = 2'd3;

    typedef enum logic [1:0] {
        CFG_TREE_DEPTH  = 2'd0,
        CFG_STEP_SIZE   = 2'd1,
        CFG_START_ROT   = 2'd2,
        CFG_START_DIR   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MV_PX = 2'd0,
        MV_PY = 2'd1,
        MV_NX = 2'd2,
        MV_NY = 2'd3
    } move_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_SETTLE = 1'b1
    } state_t;

    // one level of the recursion: code = rotation | direction << 2
    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] code;
    } frame_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic       start;
        logic       step;
        logic       settle;
        logic [2:0] start_code;
    } cell_ctl_t;

    // child frame code of each sub-curve, by parent code and phase
    localparam logic [2:0] CHILD_TAB [0:7][0:3] = '{
        '{3'd5, 3'd0, 3'd0, 3'd7},
        '{3'd6, 3'd1, 3'd1, 3'd4},
        '{3'd7, 3'd2, 3'd2, 3'd5},
        '{3'd4, 3'd3, 3'd3, 3'd6},
        '{3'd3, 3'd4, 3'd4, 3'd1},
        '{3'd0, 3'd5, 3'd5, 3'd2},
        '{3'd1, 3'd6, 3'd6, 3'd3},
        '{3'd2, 3'd7, 3'd7, 3'd0}
    };

    // connecting moves between the four sub-curves
    localparam move_t MOVE_TAB [0:7][0:2] = '{
        '{MV_PX, MV_PY, MV_NX},
        '{MV_PY, MV_NX, MV_NY},
        '{MV_NX, MV_NY, MV_PX},
        '{MV_NY, MV_PX, MV_PY},
        '{MV_PX, MV_NY, MV_NX},
        '{MV_PY, MV_PX, MV_NY},
        '{MV_NX, MV_PY, MV_PX},
        '{MV_NY, MV_NX, MV_PY}
    };

    function automatic logic [2:0] child_of(input frame_t f);
        return CHILD_TAB[f.code][f.phase];
    endfunction

    function automatic move_t move_of(input frame_t f);
        move_t m;
        case (f.phase)
            2'd0:    m = MOVE_TAB[f.code][0];
            2'd1:    m = MOVE_TAB[f.code][1];
            default: m = MOVE_TAB[f.code][2];
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/hcmg_cell.sv
// One recursion level of the Hilbert walk: frame register and neighbor links.
module hcmg_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  hcmg_pkg::cell_ctl_t ctl,
    input  logic                is_top,
    input  logic                below_top,
    input  hcmg_pkg::frame_t    parent_frame,
    input  logic                deeper_open_in,
    input  logic                above_sel_in,
    output hcmg_pkg::frame_t    frame,
    output logic                deeper_open_out,
    output logic                above_sel_out,
    output logic                sel,
    output logic [1:0]          mv_sel
);

    hcmg_pkg::frame_t frame_reg, frame_next;
    logic             pending_reg, pending_next;
    logic             open;

    assign open            = (frame_reg.phase != hcmg_pkg::PHASE_FULL);
    assign sel             = open && !deeper_open_in;   // deepest open level
    assign deeper_open_out = open || deeper_open_in;
    assign above_sel_out   = above_sel_in || sel;
    assign mv_sel          = sel ? hcmg_pkg::move_of(frame_reg) : 2'd0;
    assign frame           = frame_reg;

    always_comb
    begin
        frame_next   = frame_reg;
        pending_next = pending_reg;
        if (ctl.start)
        begin
            if (is_top)
            begin
                frame_next.phase = 2'd0;
                frame_next.code  = ctl.start_code;
            end
            else
            begin
                frame_next.phase = hcmg_pkg::PHASE_FULL;
                frame_next.code  = 3'd0;
            end
            pending_next = below_top;
        end
        else if (ctl.step)
        begin
            if (sel)
            begin
                frame_next.phase = frame_reg.phase + 2'd1;
            end
            pending_next = above_sel_in;
        end
        else if (ctl.settle && pending_reg)
        begin
            // reload first child of the parent; ripples one level per cycle
            frame_next.phase = 2'd0;
            frame_next.code  = hcmg_pkg::child_of(parent_frame);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            frame_reg   <= frame_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// File: rtl/core/hilbert_curve_move_generator_core.sv
// Hilbert curve move generator: top level with sequencer and cell chain.
//
// Input stream (s_axis): tuser = 0 starts a curve and loads the cursor from
// tdata; tuser = 1 asks for the next move. A start gives no output word. Each
// move gives one output word (m_axis): tdata = cursor after the move (x in
// the low byte, y in the high byte), tlast = final move of the curve. A move
// request when no walk runs, or after the final move, is dropped silently.
// After a move at the leaf level the block stays idle, ready for the next word; a
// move at a higher level is followed by a settle phase, with s_axis_tready
// low, while the fresh sub-curve frames ripple down the cell chain one cell
// per cycle. Three of four moves are leaf moves. A start of depth two or
// more settles the same way; tree_depth is held to 0..MAX_DEPTH.
// Latency: the output word is valid the cycle after the input word.
// The output register frees the input side: a new word is taken while one
// result waits, as long as that result is being taken in the same cycle.
// If the receiver stalls, the result holds and s_axis_tready drops.
// Reset: depth 2, step 16, rotation 0, direction 0, cursor 0, walk idle.
// cfg_we/cfg_index/cfg_wdata write one register per cycle; write only when idle, the block does not enforce it.
module hilbert_curve_move_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] start_cursor
    input  logic        s_axis_tuser,   // [0] func
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] cursor_value
    output logic        m_axis_tlast
);

    localparam int MD = hcmg_pkg::MAX_DEPTH;
    localparam int LW = hcmg_pkg::LVL_W;

    // configuration registers
    logic [hcmg_pkg::DEPTH_W-1:0] depth_reg;
    logic [hcmg_pkg::STEP_W-1:0]  step_reg;
    logic [1:0]                   rot_reg;
    logic                         dir_reg;

    // walk state
    hcmg_pkg::state_t              state_reg, state_next;
    logic [LW-1:0]                 settle_cnt_reg, settle_cnt_next;
    logic [hcmg_pkg::CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [hcmg_pkg::MOVES_W-1:0]  moves_left_reg, moves_left_next;
    logic                          walk_active_reg, walk_active_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [hcmg_pkg::CURSOR_W-1:0] out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    // cell chain links
    hcmg_pkg::cell_ctl_t ctl;
    hcmg_pkg::frame_t    frames [MD];
    hcmg_pkg::frame_t    parent [MD];
    logic [MD:0]         open_chain;
    logic [MD:0]         sel_chain;
    logic [MD-1:0]       sel_vec;
    logic [MD-1:0]       is_top_vec;
    logic [MD-1:0]       below_top_vec;
    logic [1:0]          mv_sel [MD];

    logic                          in_fire, do_start, do_step, step_req, no_open;
    logic [hcmg_pkg::DEPTH_W-1:0]  depth_sat;
    logic [LW-1:0]                 top_lvl, sel_lvl;
    logic [1:0]                    mv_bits;
    hcmg_pkg::move_t               mv;
    logic [hcmg_pkg::CURSOR_W-1:0] delta;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= hcmg_pkg::DEPTH_W'(2);
            step_reg  <= hcmg_pkg::STEP_W'(16);
            rot_reg   <= 2'd0;
            dir_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (hcmg_pkg::cfg_reg_t'(cfg_index))
                hcmg_pkg::CFG_TREE_DEPTH: depth_reg <= cfg_wdata[hcmg_pkg::DEPTH_W-1:0];
                hcmg_pkg::CFG_STEP_SIZE:  step_reg  <= cfg_wdata[hcmg_pkg::STEP_W-1:0];
                hcmg_pkg::CFG_START_ROT:  rot_reg   <= cfg_wdata[1:0];
                hcmg_pkg::CFG_START_DIR:  dir_reg   <= cfg_wdata[0];
                default:                  ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s_axis_tready = (state_reg == hcmg_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign do_start      = in_fire && !s_axis_tuser;
    assign step_req      = in_fire && s_axis_tuser && walk_active_reg && (moves_left_reg != '0);
    assign no_open       = !open_chain[0];
    assign do_step       = step_req && !no_open;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------- level selects ----------------
    assign depth_sat = (depth_reg > hcmg_pkg::DEPTH_W'(MD)) ? hcmg_pkg::DEPTH_W'(MD) : depth_reg;
    assign top_lvl   = LW'(MD - int'(depth_sat));

    always_comb
    begin
        sel_lvl = '0;
        for (int i = 0; i < MD; i++)
        begin
            is_top_vec[i]    = (depth_sat != '0) && (LW'(i) == top_lvl);
            below_top_vec[i] = (depth_sat != '0) && (LW'(i) > top_lvl);
            if (sel_vec[i])
            begin
                sel_lvl = LW'(i);
            end
        end
    end

    assign ctl.start      = do_start;
    assign ctl.step       = do_step;
    assign ctl.settle     = (state_reg == hcmg_pkg::ST_SETTLE);
    assign ctl.start_code = {dir_reg, rot_reg};

    // ---------------- cell chain, level 0 at the top ----------------
    assign open_chain[MD] = 1'b0;
    assign sel_chain[0]   = 1'b0;

    for (genvar g = 0; g < MD; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign parent[g] = '0;
        end
        else begin : g_link
            assign parent[g] = frames[g-1];
        end

        hcmg_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctl             (ctl),
            .is_top          (is_top_vec[g]),
            .below_top       (below_top_vec[g]),
            .parent_frame    (parent[g]),
            .deeper_open_in  (open_chain[g+1]),
            .above_sel_in    (sel_chain[g]),
            .frame           (frames[g]),
            .deeper_open_out (open_chain[g]),
            .above_sel_out   (sel_chain[g+1]),
            .sel             (sel_vec[g]),
            .mv_sel          (mv_sel[g])
        );
    end

    // only the selected cell drives a nonzero move code
    always_comb
    begin
        mv_bits = 2'd0;
        for (int i = 0; i < MD; i++)
        begin
            mv_bits = mv_bits | mv_sel[i];
        end
    end

    assign mv    = hcmg_pkg::move_t'(mv_bits);
    assign delta = (mv == hcmg_pkg::MV_PX || mv == hcmg_pkg::MV_NX)
                 ? {8'd0, step_reg} : {step_reg, 8'd0};

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        settle_cnt_next  = settle_cnt_reg;
        cursor_next      = cursor_reg;
        moves_left_next  = moves_left_reg;
        walk_active_next = walk_active_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            hcmg_pkg::ST_IDLE:
            begin
                if (do_start)
                begin
                    cursor_next = s_axis_tdata;
                    if (depth_sat == '0)
                    begin
                        moves_left_next  = '0;
                        walk_active_next = 1'b0;
                    end
                    else
                    begin
                        moves_left_next  = hcmg_pkg::MOVES_W'(
                            ((hcmg_pkg::MOVES_W+1)'(1) << (2 * depth_sat)) - 1'b1);
                        walk_active_next = 1'b1;
                        if (depth_sat > hcmg_pkg::DEPTH_W'(1))
                        begin
                            settle_cnt_next = LW'(depth_sat - 1'b1);
                            state_next      = hcmg_pkg::ST_SETTLE;
                        end
                    end
                end
                else if (step_req && no_open)
                begin
                    walk_active_next = 1'b0;
                    moves_left_next  = '0;
                end
                else if (do_step)
                begin
                    if (mv == hcmg_pkg::MV_PX || mv == hcmg_pkg::MV_PY)
                    begin
                        cursor_next = cursor_reg + delta;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - delta;
                    end
                    moves_left_next = moves_left_reg - 1'b1;
                    if (moves_left_reg == hcmg_pkg::MOVES_W'(1))
                    begin
                        walk_active_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = cursor_next;
                    out_last_next  = (moves_left_reg == hcmg_pkg::MOVES_W'(1));
                    // levels below the moving one need fresh first-child frames
                    if (sel_lvl != LW'(MD - 1))
                    begin
                        settle_cnt_next = LW'(MD - 1) - sel_lvl;
                        state_next      = hcmg_pkg::ST_SETTLE;
                    end
                end
            end
            hcmg_pkg::ST_SETTLE:
            begin
                settle_cnt_next = settle_cnt_reg - 1'b1;
                if (settle_cnt_reg == LW'(1))
                begin
                    state_next = hcmg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcmg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hcmg_pkg::ST_IDLE;
            settle_cnt_reg  <= '0;
            cursor_reg      <= '0;
            moves_left_reg  <= '0;
            walk_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            settle_cnt_reg  <= settle_cnt_next;
            cursor_reg      <= cursor_next;
            moves_left_reg  <= moves_left_next;
            walk_active_reg <= walk_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: rtl/core/hcmg_checker.sv
// Port-level checker for the Hilbert move generator, bound to the top level.
`include "hilbert_curve_move_generator_core_macros.svh"

module hcmg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled word stays offered
    `HCMG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")

    // stalled word keeps its payload
    `HCMG_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "output payload changed while stalled")

    // a blocked output register must stop the input side
    `HCMG_ASSERT_SAME(a_no_take_blocked, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output blocked")

    // a start word never produces an output word
    `HCMG_ASSERT_NEXT(a_start_silent, s_axis_tvalid && s_axis_tready && !s_axis_tuser && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid, "start produced an output word")

endmodule

bind hilbert_curve_move_generator_core hcmg_checker u_hcmg_checker (.*);

// File: dv/hilbert_curve_move_generator_core_checker.sv
// Checker for the Hilbert move generator: tracks the curve walk and compares output words.
`timescale 1ns / 100ps

module hilbert_curve_move_generator_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] start_cursor
    input  logic        s_axis_tuser,   // [0] func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] cursor_value
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          pending_moves
);

    typedef struct packed {
        logic [15:0] cursor;
        logic        last;
    } move_word_t;

    move_word_t  expected_moves [$];
    move_word_t  head;

    // shadow registers and walk state
    logic [3:0]       depth_reg;
    logic [7:0]       step_reg;
    logic [1:0]       rot_reg;
    logic             dir_reg;
    logic [15:0]      cursor;
    hcmg_pkg::frame_t frames [hcmg_pkg::MAX_DEPTH];
    logic [15:0]      moves_left;
    logic             walking;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // levels from..MAX_DEPTH-1 take the first sub-curve of the level above
    task automatic refill(input int from);
        hcmg_pkg::frame_t up;
        logic [1:0]       r;
        logic             d;
        logic [2:0]       kid;
        int               i;
        for (i = from; i < hcmg_pkg::MAX_DEPTH; i++) begin
            up = frames[i-1];
            r  = up.code[1:0];
            d  = up.code[2];
            case (up.phase)
                // outer sub-curves turn a quarter and flip sense
                2'd0: begin
                    r   = d ? r + 2'd3 : r + 2'd1;
                    kid = {~d, r};
                end
                2'd3: begin
                    r   = d ? r + 2'd1 : r + 2'd3;
                    kid = {~d, r};
                end
                default: kid = up.code;
            endcase
            frames[i].code  = kid;
            frames[i].phase = 2'd0;
        end
    endtask

    task automatic advance_curve(input logic fn, input logic [15:0] d);
        int               eff;
        int               lvl;
        int               i;
        hcmg_pkg::frame_t fr;
        logic [1:0]       turn;
        hcmg_pkg::move_t  mv;
        logic [15:0]      delta;
        if (!fn) begin
            eff    = (depth_reg > hcmg_pkg::MAX_DEPTH) ? hcmg_pkg::MAX_DEPTH : depth_reg;
            cursor = d;
            for (i = 0; i < hcmg_pkg::MAX_DEPTH; i++) begin
                frames[i].code  = 3'd0;
                frames[i].phase = hcmg_pkg::PHASE_FULL;
            end
            if (eff == 0) begin
                moves_left = 16'd0;
                walking    = 1'b0;
            end else begin
                lvl               = hcmg_pkg::MAX_DEPTH - eff;
                frames[lvl].code  = {dir_reg, rot_reg};
                frames[lvl].phase = 2'd0;
                refill(lvl + 1);
                moves_left = 16'((32'd1 << (2 * eff)) - 32'd1);
                walking    = 1'b1;
            end
        end else if (walking && moves_left != 16'd0) begin
            lvl = -1;
            for (i = hcmg_pkg::MAX_DEPTH - 1; i >= 0; i--)
                if (lvl < 0 && frames[i].phase != hcmg_pkg::PHASE_FULL)
                    lvl = i;
            if (lvl < 0) begin
                walking    = 1'b0;
                moves_left = 16'd0;
            end else begin
                fr = frames[lvl];
                // connecting move: rotation plus 0, 1 or 2 quarters (0, 3, 2 reversed)
                case (fr.phase)
                    2'd0:    turn = 2'd0;
                    2'd1:    turn = fr.code[2] ? 2'd3 : 2'd1;
                    default: turn = 2'd2;
                endcase
                mv = hcmg_pkg::move_t'(fr.code[1:0] + turn);
                frames[lvl].phase = fr.phase + 2'd1;
                refill(lvl + 1);
                delta = (mv == hcmg_pkg::MV_PX || mv == hcmg_pkg::MV_NX)
                      ? {8'h00, step_reg} : {step_reg, 8'h00};
                cursor = (mv == hcmg_pkg::MV_PX || mv == hcmg_pkg::MV_PY)
                       ? cursor + delta : cursor - delta;
                moves_left = moves_left - 16'd1;
                if (moves_left == 16'd0)
                    walking = 1'b0;
                expected_moves.push_back({cursor, moves_left == 16'd0});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            depth_reg  = 4'd2;
            step_reg   = 8'd16;
            rot_reg    = 2'd0;
            dir_reg    = 1'b0;
            cursor     = 16'd0;
            moves_left = 16'd0;
            walking    = 1'b0;
            for (int i = 0; i < hcmg_pkg::MAX_DEPTH; i++)
                frames[i] = '0;
            expected_moves.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_moves.size() == 0)
                    report_mismatch("word with none expected", m_axis_tdata, 16'h0000);
                else begin
                    head = expected_moves.pop_front();
                    if (m_axis_tdata !== head.cursor)
                        report_mismatch("cursor", m_axis_tdata, head.cursor);
                    if (m_axis_tlast !== head.last)
                        report_mismatch("last flag", {15'd0, m_axis_tlast}, {15'd0, head.last});
                end
            end
            if (cfg_we) begin
                case (hcmg_pkg::cfg_reg_t'(cfg_index))
                    hcmg_pkg::CFG_TREE_DEPTH: depth_reg = cfg_wdata[3:0];
                    hcmg_pkg::CFG_STEP_SIZE:  step_reg  = cfg_wdata;
                    hcmg_pkg::CFG_START_ROT:  rot_reg   = cfg_wdata[1:0];
                    hcmg_pkg::CFG_START_DIR:  dir_reg   = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_curve(s_axis_tuser, s_axis_tdata);
        end
        pending_moves = expected_moves.size();
    end

endmodule

// File: dv/hilbert_curve_move_generator_core_tb.sv
// Testbench top for the Hilbert move generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module hilbert_curve_move_generator_core_tb;

    // stop making new words once this many have gone in
    localparam int TARGET_WORDS  = 1350;
    // quiet time after the last expected word: covers a start
    // or a high-level move rippling down the cell chain
    localparam int SETTLE_CYCLES = 24;
    // hard stop; the slowest legal run is far below this
    localparam int CYCLE_LIMIT   = 600000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = 2'd0;
    logic [7:0]  cfg_wdata     = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;   // [15:0] start_cursor
    logic        s_axis_tuser  = 1'b0;    // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] cursor_value
    logic        m_axis_tlast;

    int mismatches;
    int pending_moves;
    int words_sent;
    int cycles;

    // idle_on: both sides insert random gaps; off gives back-to-back stretches
    bit idle_on = 1'b1;
    int rx_hold;
    int rx_pick;

    // depth register value the block holds now, for sizing the walks
    logic [3:0] cur_depth = 4'd2;

    hilbert_curve_move_generator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    hilbert_curve_move_generator_core_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending_moves (pending_moves)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output side back-pressure, with idle_on set: ready on most picks, short
    // stalls, now and then a long one. A hold counter, loaded at random, keeps
    // each choice in place so stalls land on every phase of the move pipeline.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!idle_on)
            m_axis_tready <= 1'b1;
        else if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 60) begin
                m_axis_tready <= 1'b1;
                rx_hold       <= $urandom_range(0, 3);
            end else if (rx_pick < 95) begin
                m_axis_tready <= 1'b0;
                rx_hold       <= $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rx_hold       <= $urandom_range(10, 40);
            end
        end
    end

    // Watchdog: a hang in either handshake ends the run here.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One input word. An optional gap first, then valid holds until the
    // block takes the word. Valid is left high on return, so a back-to-back
    // word never sees valid drop and rise in the same step.
    task automatic push_item(input logic fn, input logic [15:0] d);
        int gap;
        int r;
        gap = 0;
        if (idle_on) begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 30);
            else if (r >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= d;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Hold the input off until every predicted word is out, then let any
    // start or ripple still inside the block finish. Polled on the falling
    // edge so the checker's count is settled.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending_moves != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the selected registers, one per cycle; call only after settle().
    task automatic program_regs(input bit [3:0] sel, input logic [7:0] v_depth,
                                input logic [7:0] v_step, input logic [7:0] v_rot,
                                input logic [7:0] v_dir);
        int                 k;
        hcmg_pkg::cfg_reg_t idx;
        for (k = 0; k < 4; k++) begin
            if (sel[k]) begin
                idx = hcmg_pkg::cfg_reg_t'(k);
                cfg_we    <= 1'b1;
                cfg_index <= idx;
                case (idx)
                    hcmg_pkg::CFG_TREE_DEPTH: begin
                        cfg_wdata <= v_depth;
                        cur_depth  = v_depth[3:0];
                    end
                    hcmg_pkg::CFG_STEP_SIZE:  cfg_wdata <= v_step;
                    hcmg_pkg::CFG_START_ROT:  cfg_wdata <= v_rot;
                    default:                  cfg_wdata <= v_dir;
                endcase
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int          eff;
        int          full;
        int          n;
        int          i;
        int          rd;
        logic [3:0]  dep;
        logic [7:0]  sv;
        logic [15:0] start_val;

        words_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset settings: depth 2, step 16, rot 0, dir 0
        // step before any start: walk idle, nothing comes out
        push_item(1'b1, 16'hA5A5);
        // full depth-2 curve from the origin, last flag on move 15
        push_item(1'b0, 16'h0000);
        for (i = 0; i < 15; i++)
            push_item(1'b1, 16'(i * 16'h1111));
        // step after the final move is dropped
        push_item(1'b1, 16'hFFFF);

        // depth zero: start loads the cursor, walk stays idle
        settle();
        program_regs(4'b1111, 8'd0, 8'd255, 8'd3, 8'd1);
        push_item(1'b0, 16'hFFFF);
        push_item(1'b1, 16'h0000);

        // depth 1, widest step, rot 3 reversed: moves from 0 borrow through y
        settle();
        program_regs(4'b0001, 8'd1, 8'd0, 8'd0, 8'd0);
        push_item(1'b0, 16'h0000);
        for (i = 0; i < 4; i++)
            push_item(1'b1, 16'h5A5A);

        // ---- random part: one curve per pass, settings changed between
        while (words_sent < TARGET_WORDS) begin
            settle();
            idle_on = ($urandom_range(0, 4) != 0);

            // depth mostly small so curves finish; a few deep or saturating
            rd = $urandom_range(0, 99);
            if (rd < 8)
                dep = 4'd0;
            else if (rd < 38)
                dep = 4'd1;
            else if (rd < 64)
                dep = 4'd2;
            else if (rd < 80)
                dep = 4'd3;
            else if (rd < 90)
                dep = 4'($urandom_range(4, 7));
            else if (rd < 95)
                dep = 4'd8;
            else
                dep = 4'($urandom_range(9, 15));
            rd = $urandom_range(0, 99);
            sv = (rd < 10) ? 8'd0 : (rd < 20) ? 8'd255 : 8'($urandom());

            // every register has a fair chance; unused upper bits get junk
            program_regs(4'($urandom_range(1, 15)) | ($urandom_range(0, 2) == 0 ? 4'b1111 : 4'b0001),
                         {($urandom_range(0, 1) ? 4'($urandom()) : 4'h0), dep},
                         sv,
                         {($urandom_range(0, 1) ? 6'($urandom()) : 6'h00), 2'($urandom())},
                         {($urandom_range(0, 1) ? 7'($urandom()) : 7'h00), 1'($urandom())});

            eff  = (cur_depth > hcmg_pkg::MAX_DEPTH) ? hcmg_pkg::MAX_DEPTH : cur_depth;
            full = (1 << (2 * eff)) - 1;
            if (eff == 0)
                n = $urandom_range(1, 3);
            else if (eff <= 3 || (eff == 4 && $urandom_range(0, 2) == 0)) begin
                if (full > 1 && $urandom_range(0, 99) < 15)
                    n = $urandom_range(1, full - 1);
                else
                    n = full + $urandom_range(0, 2);
            end else
                n = $urandom_range(10, 80);

            // noise: a stray step before the start, or a double start
            if ($urandom_range(0, 9) == 0)
                push_item(1'b1, 16'($urandom()));
            if ($urandom_range(0, 19) == 0)
                push_item(1'b0, 16'($urandom()));

            rd = $urandom_range(0, 99);
            start_val = (rd < 10) ? 16'h0000 : (rd < 20) ? 16'hFFFF : 16'($urandom());
            push_item(1'b0, start_val);

            // the last pass stops at the word target
            for (i = 0; i < n && words_sent < TARGET_WORDS; i++) begin
                // mid-walk: drain fully, then change registers; step size
                // takes effect at once, the rest only at the next start
                if (i == n / 2 && n > 4 && $urandom_range(0, 4) == 0) begin
                    settle();
                    program_regs(4'($urandom_range(0, 15)) | 4'b0010,
                                 8'($urandom_range(0, 15)), 8'($urandom()),
                                 8'($urandom()), 8'($urandom()));
                end
                push_item(1'b1, 16'($urandom()));
            end
        end

        // drain and let the block go quiet before the verdict
        settle();
        if (mismatches == 0 && pending_moves == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
